[hw/rtl/filtered_overwriting_trace_buffer_unit_defines.svh]
// ----------------------------------------------------------------------------
// trace buffer assertion macros
// concurrent checks for the trace buffer top unit, clocked on clk_i and
// held off while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef FILTERED_OVERWRITING_TRACE_BUFFER_UNIT_DEFINES_SVH
`define FILTERED_OVERWRITING_TRACE_BUFFER_UNIT_DEFINES_SVH

// same-cycle implication
`define FOTB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FOTB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/fotb_pkg.sv]
// ----------------------------------------------------------------------------
// fotb_pkg
// shared types for the filtered overwriting trace buffer
// ----------------------------------------------------------------------------
package fotb_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 64;

  typedef enum logic [1:0] {
    MODE_RECORD = 2'd0,
    MODE_POP    = 2'd1,
    MODE_PEEK   = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RECORDING = 2'd0,
    CFG_FILTER_LO = 2'd1,
    CFG_FILTER_HI = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic load;
    logic exec;
  } dp_cmd_t;

endpackage

[hw/rtl/fotb_ctrl.sv]
// ----------------------------------------------------------------------------
// fotb_ctrl
// handshake controller: takes a word, runs it through the execute state,
// holds the result until the receiver takes it
// ----------------------------------------------------------------------------
module fotb_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output fotb_pkg::dp_cmd_t cmd_o
);

  fotb_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fotb_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      fotb_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = fotb_pkg::ST_EXEC;
        end
      end
      fotb_pkg::ST_EXEC: begin
        state_d = fotb_pkg::ST_RESP;
      end
      fotb_pkg::ST_RESP: begin
        if (out_ready_i) begin
          state_d = in_valid_i ? fotb_pkg::ST_EXEC : fotb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = fotb_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o.exec  = 1'b0;
    case (state_q)
      fotb_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      fotb_pkg::ST_EXEC: begin
        cmd_o.exec = 1'b1;
      end
      fotb_pkg::ST_RESP: begin
        out_valid_o = 1'b1;
        in_ready_o  = out_ready_i;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
    cmd_o.load = in_valid_i && in_ready_o;
  end

endmodule

[hw/rtl/fotb_dp.sv]
// ----------------------------------------------------------------------------
// fotb_dp
// trace ring datapath: entry memory, pointers, fill count, overflow count,
// filter and recording registers and result registers
// ----------------------------------------------------------------------------
module fotb_dp #(
  parameter int unsigned DEPTH = 256
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  fotb_pkg::dp_cmd_t            cmd_i,
  input  logic                         cfg_we_i,
  input  logic [fotb_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [fotb_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic [1:0]                   mode_i,
  input  logic [7:0]                   event_code_i,
  input  logic [7:0]                   task_number_i,
  input  logic [15:0]                  short_param_i,
  input  logic [31:0]                  long_param_i,
  input  logic [31:0]                  stamp_i,
  input  logic [7:0]                   peek_offset_i,
  output logic                         ok_o,
  output logic [31:0]                  out_stamp_o,
  output logic [7:0]                   out_event_o,
  output logic [7:0]                   out_task_o,
  output logic [15:0]                  out_short_param_o,
  output logic [31:0]                  out_long_param_o,
  output logic [8:0]                   fill_level_o,
  output logic [31:0]                  overflow_total_o
);

  localparam int unsigned PtrW   = $clog2(DEPTH);
  localparam int unsigned CntW   = $clog2(DEPTH + 1);
  localparam int unsigned SumW   = ((PtrW > 8) ? PtrW : 8) + 1;
  localparam int unsigned EntryW = 96;

  // captured word
  fotb_pkg::mode_e mode_q;
  logic [7:0]      code_q;
  logic [7:0]      task_q;
  logic [15:0]     sparam_q;
  logic [31:0]     lparam_q;
  logic [31:0]     stamp_q;
  logic [7:0]      offset_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q   <= fotb_pkg::mode_e'(mode_i);
      code_q   <= event_code_i;
      task_q   <= task_number_i;
      sparam_q <= short_param_i;
      lparam_q <= long_param_i;
      stamp_q  <= stamp_i;
      offset_q <= peek_offset_i;
    end
  end

  // configuration
  logic         recording_q;
  logic [127:0] filter_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recording_q <= 1'b0;
      filter_q    <= '1;
    end else if (cfg_we_i) begin
      case (fotb_pkg::cfg_idx_e'(cfg_idx_i))
        fotb_pkg::CFG_RECORDING: recording_q <= cfg_wdata_i[0];
        fotb_pkg::CFG_FILTER_LO: filter_q[63:0] <= cfg_wdata_i;
        fotb_pkg::CFG_FILTER_HI: filter_q[127:64] <= cfg_wdata_i;
        default: begin
          recording_q <= recording_q;
        end
      endcase
    end
  end

  // ring state
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic [31:0]     ovf_q, ovf_d;
  logic            ok_q, ok_d;
  logic            ret_q, ret_d;

  logic            code_en;
  logic            full;
  logic            store;
  logic            pop_ok;
  logic            peek_ok;
  logic [PtrW-1:0] wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_nxt;
  logic [SumW-1:0] slot_sum;
  logic [SumW-1:0] slot_wrap;
  logic            mem_we;
  logic            mem_re;
  logic [PtrW-1:0] mem_raddr;

  assign code_en    = !code_q[7] && filter_q[code_q[6:0]];
  assign full       = (count_q == CntW'(DEPTH));
  assign wr_ptr_nxt = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
  assign rd_ptr_nxt = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
  assign slot_sum   = SumW'(rd_ptr_q) + SumW'(offset_q);
  assign slot_wrap  = (slot_sum >= SumW'(DEPTH)) ? slot_sum - SumW'(DEPTH) : slot_sum;

  assign store   = (mode_q == fotb_pkg::MODE_RECORD) && recording_q && code_en;
  assign pop_ok  = (mode_q == fotb_pkg::MODE_POP) && (count_q != '0);
  assign peek_ok = (mode_q == fotb_pkg::MODE_PEEK) && (SumW'(offset_q) < SumW'(count_q));

  always_comb begin
    wr_ptr_d  = wr_ptr_q;
    rd_ptr_d  = rd_ptr_q;
    count_d   = count_q;
    ovf_d     = ovf_q;
    ok_d      = ok_q;
    ret_d     = ret_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_raddr = rd_ptr_q;
    if (cmd_i.exec) begin
      ok_d  = store || pop_ok || peek_ok;
      ret_d = pop_ok || peek_ok;
      case (mode_q)
        fotb_pkg::MODE_RECORD: begin
          if (store) begin
            mem_we   = 1'b1;
            wr_ptr_d = wr_ptr_nxt;
            if (full) begin
              rd_ptr_d = rd_ptr_nxt;
              ovf_d    = ovf_q + 32'd1;
            end else begin
              count_d = count_q + CntW'(1);
            end
          end
        end
        fotb_pkg::MODE_POP: begin
          if (pop_ok) begin
            mem_re   = 1'b1;
            rd_ptr_d = rd_ptr_nxt;
            count_d  = count_q - CntW'(1);
          end
        end
        fotb_pkg::MODE_PEEK: begin
          if (peek_ok) begin
            mem_re    = 1'b1;
            mem_raddr = slot_wrap[PtrW-1:0];
          end
        end
        fotb_pkg::MODE_CLEAR: begin
          wr_ptr_d = '0;
          rd_ptr_d = '0;
          count_d  = '0;
          ovf_d    = '0;
        end
        default: begin
          ok_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
      ovf_q    <= '0;
      ok_q     <= 1'b0;
      ret_q    <= 1'b0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
      ovf_q    <= ovf_d;
      ok_q     <= ok_d;
      ret_q    <= ret_d;
    end
  end

  // entry memory: stamp, long param, event, task, short param
  logic [EntryW-1:0] mem_q [DEPTH];
  logic [EntryW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_ptr_q] <= {stamp_q, lparam_q, code_q, task_q, sparam_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  // result
  logic [CntW+8:0] count_ext;

  assign count_ext         = (CntW + 9)'(count_q);
  assign ok_o              = ok_q;
  assign out_stamp_o       = ret_q ? rdata_q[95:64] : '0;
  assign out_long_param_o  = ret_q ? rdata_q[63:32] : '0;
  assign out_event_o       = ret_q ? rdata_q[31:24] : '0;
  assign out_task_o        = ret_q ? rdata_q[23:16] : '0;
  assign out_short_param_o = ret_q ? rdata_q[15:0] : '0;
  assign fill_level_o      = count_ext[8:0];
  assign overflow_total_o  = ovf_q;

endmodule

[hw/rtl/filtered_overwriting_trace_buffer_unit.sv]
// ----------------------------------------------------------------------------
// filtered_overwriting_trace_buffer_unit
// Trace capture ring with a 128-bit event filter and overwrite on full.
// Input channel (in_valid_i / in_ready_o) carries one command word: record,
// pop oldest, peek at offset or clear. Output channel (out_valid_o /
// out_ready_i) returns exactly one result word per command, in order.
// Configuration is a plain write port: cfg_we_i, cfg_idx_i, cfg_wdata_i
// (0 recording enable, 1 filter codes 0-63, 2 filter codes 64-127).
// After the command is taken it passes through the execute state, which does
// the ring update and the registered memory read, then the result state.
// A command is held in the execute and result states of the controller, so
// no new command is taken while it is in the execute state.
// A new command is taken in the same cycle the pending result is taken.
// While the receiver stalls the result holds and no command is taken.
// Reset empties the ring, zeroes the overflow count, turns recording off
// and opens the filter to codes 0-127; entry memory is not cleared, so the
// block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
`include "filtered_overwriting_trace_buffer_unit_defines.svh"

module filtered_overwriting_trace_buffer_unit #(
  parameter int unsigned DEPTH = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [fotb_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [fotb_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    mode_i,
  input  logic [7:0]                    event_code_i,
  input  logic [7:0]                    task_number_i,
  input  logic [15:0]                   short_param_i,
  input  logic [31:0]                   long_param_i,
  input  logic [31:0]                   stamp_i,
  input  logic [7:0]                    peek_offset_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          ok_o,
  output logic [31:0]                   out_stamp_o,
  output logic [7:0]                    out_event_o,
  output logic [7:0]                    out_task_o,
  output logic [15:0]                   out_short_param_o,
  output logic [31:0]                   out_long_param_o,
  output logic [8:0]                    fill_level_o,
  output logic [31:0]                   overflow_total_o
);

  fotb_pkg::dp_cmd_t cmd;

  fotb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  fotb_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .mode_i            (mode_i),
    .event_code_i      (event_code_i),
    .task_number_i     (task_number_i),
    .short_param_i     (short_param_i),
    .long_param_i      (long_param_i),
    .stamp_i           (stamp_i),
    .peek_offset_i     (peek_offset_i),
    .ok_o              (ok_o),
    .out_stamp_o       (out_stamp_o),
    .out_event_o       (out_event_o),
    .out_task_o        (out_task_o),
    .out_short_param_o (out_short_param_o),
    .out_long_param_o  (out_long_param_o),
    .fill_level_o      (fill_level_o),
    .overflow_total_o  (overflow_total_o)
  );

  `FOTB_ASSERT_NOW(a_no_take_while_stalled, out_valid_o && !out_ready_i, !in_ready_o,
                   "command taken while result is stalled")

  `FOTB_ASSERT_NEXT(a_result_two_cycles, in_valid_i && in_ready_o,
                    !out_valid_o ##1 out_valid_o, "result not valid two cycles after take")

  `FOTB_ASSERT_NOW(a_failed_returns_zero, out_valid_o && !ok_o,
                   out_stamp_o == 32'd0 && out_long_param_o == 32'd0 && out_event_o == 8'd0,
                   "entry fields not zero on failed command")

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trace buffer testbench
// drives record, pop, peek and clear words into the trace ring under random
// idling on both channels, predicts each result word from a local copy of
// the ring, pointers, filter and overflow count or takes it from the directed
// table, and checks each returned word field by field; that table opens the
// run, random bursts that fill, overwrite and drain the ring follow across
// several register settings
module tb_top;

  localparam int unsigned RING_DEPTH = 256;
  localparam int unsigned PHASE_WORDS = 148;
  localparam int unsigned QUIET_LIMIT = 5000;
  localparam int unsigned TAIL_CYCLES = 8;
  localparam logic [fotb_pkg::CfgIdxW-1:0] CFG_IDX_SPARE = 2'd3;

  typedef struct packed {
    fotb_pkg::mode_e mode;
    logic [7:0]      code;
    logic [7:0]      tsk;
    logic [15:0]     sparam;
    logic [31:0]     lparam;
    logic [31:0]     stamp;
    logic [7:0]      offset;
  } trace_word_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] stamp;
    logic [7:0]  evt;
    logic [7:0]  tsk;
    logic [15:0] sparam;
    logic [31:0] lparam;
    logic [8:0]  fill;
    logic [31:0] ovf;
  } trace_result_t;

  typedef struct {
    logic                          is_cfg;
    logic [fotb_pkg::CfgIdxW-1:0]  idx;
    logic [fotb_pkg::CfgDataW-1:0] data;
    trace_word_t                   word;
    logic                          typed;
    trace_result_t                 res;
  } plan_row_t;

  typedef enum logic [1:0] {
    BURST_FILL,
    BURST_DRAIN,
    BURST_MIXED
  } burst_e;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we_i = 1'b0;
  logic [fotb_pkg::CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [fotb_pkg::CfgDataW-1:0] cfg_wdata_i = '0;
  logic                          in_valid_i = 1'b0;
  logic                          in_ready_o;
  logic [1:0]                    mode_i = '0;
  logic [7:0]                    event_code_i = '0;
  logic [7:0]                    task_number_i = '0;
  logic [15:0]                   short_param_i = '0;
  logic [31:0]                   long_param_i = '0;
  logic [31:0]                   stamp_i = '0;
  logic [7:0]                    peek_offset_i = '0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  logic                          ok_o;
  logic [31:0]                   out_stamp_o;
  logic [7:0]                    out_event_o;
  logic [7:0]                    out_task_o;
  logic [15:0]                   out_short_param_o;
  logic [31:0]                   out_long_param_o;
  logic [8:0]                    fill_level_o;
  logic [31:0]                   overflow_total_o;

  logic          pin_typed = 1'b0;
  trace_result_t pin_result = '0;

  // local copy of the ring
  logic [63:0] ring_stamp_long [RING_DEPTH];
  logic [31:0] ring_tag [RING_DEPTH];
  logic [7:0]  wr_ptr = '0;
  logic [7:0]  rd_ptr = '0;
  logic [8:0]  fill = '0;
  logic [31:0] overflow = '0;
  logic        rec_on = 1'b0;
  logic [63:0] filt_lo = '1;
  logic [63:0] filt_hi = '1;

  trace_result_t pending_results [$];
  plan_row_t     plan [$];

  int unsigned words_sent = 0;
  int unsigned results_seen = 0;
  int unsigned fault_count = 0;
  int unsigned kept_count = 0;
  int unsigned returned_count = 0;
  int unsigned overwrite_count = 0;
  int unsigned peak_fill = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_gap_pct = 19;
  int unsigned sink_stall_pct = 74;

  filtered_overwriting_trace_buffer_unit #(
    .DEPTH(RING_DEPTH)
  ) u_top (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_ready_o,
    .mode_i,
    .event_code_i,
    .task_number_i,
    .short_param_i,
    .long_param_i,
    .stamp_i,
    .peek_offset_i,
    .out_valid_o,
    .out_ready_i,
    .ok_o,
    .out_stamp_o,
    .out_event_o,
    .out_task_o,
    .out_short_param_o,
    .out_long_param_o,
    .fill_level_o,
    .overflow_total_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic trace_word_t mk_word(fotb_pkg::mode_e m, logic [7:0] code,
                                          logic [7:0] tsk, logic [15:0] sparam,
                                          logic [31:0] lparam, logic [31:0] stamp,
                                          logic [7:0] offset);
    trace_word_t w;
    w = '{m, code, tsk, sparam, lparam, stamp, offset};
    return w;
  endfunction

  function automatic trace_result_t mk_result(logic ok, logic [31:0] stamp, logic [7:0] evt,
                                              logic [7:0] tsk, logic [15:0] sparam,
                                              logic [31:0] lparam, logic [8:0] fill_now);
    trace_result_t r;
    r = '{ok, stamp, evt, tsk, sparam, lparam, fill_now, 32'd0};
    return r;
  endfunction

  function automatic plan_row_t cfg_row(logic [fotb_pkg::CfgIdxW-1:0] idx,
                                        logic [fotb_pkg::CfgDataW-1:0] data);
    plan_row_t row;
    row = '{1'b1, idx, data, '0, 1'b0, '0};
    return row;
  endfunction

  function automatic plan_row_t word_row(trace_word_t w, logic typed, trace_result_t res);
    plan_row_t row;
    row = '{1'b0, '0, '0, w, typed, res};
    return row;
  endfunction

  function automatic trace_result_t ring_entry(logic [7:0] slot);
    trace_result_t r;
    r = '0;
    r.ok = 1'b1;
    r.stamp = ring_stamp_long[slot][63:32];
    r.lparam = ring_stamp_long[slot][31:0];
    {r.evt, r.tsk, r.sparam} = ring_tag[slot];
    return r;
  endfunction

  // updates the local ring and returns the result word it implies
  function automatic trace_result_t apply_trace_word(trace_word_t w);
    trace_result_t r;
    logic          enabled;
    r = '0;
    case (w.mode)
      fotb_pkg::MODE_RECORD: begin
        enabled = w.code[7] ? 1'b0 : (w.code[6] ? filt_hi[w.code[5:0]] : filt_lo[w.code[5:0]]);
        if (rec_on && enabled) begin
          ring_stamp_long[wr_ptr] = {w.stamp, w.lparam};
          ring_tag[wr_ptr] = {w.code, w.tsk, w.sparam};
          wr_ptr = wr_ptr + 8'd1;
          if (fill < RING_DEPTH) begin
            fill = fill + 9'd1;
          end else begin
            rd_ptr = rd_ptr + 8'd1;
            overflow = overflow + 32'd1;
            overwrite_count++;
          end
          r.ok = 1'b1;
          kept_count++;
        end
      end
      fotb_pkg::MODE_POP: begin
        if (fill != 0) begin
          r = ring_entry(rd_ptr);
          rd_ptr = rd_ptr + 8'd1;
          fill = fill - 9'd1;
          returned_count++;
        end
      end
      fotb_pkg::MODE_PEEK: begin
        if (w.offset < fill) begin
          r = ring_entry(rd_ptr + w.offset);
          returned_count++;
        end
      end
      default: begin
        wr_ptr = '0;
        rd_ptr = '0;
        fill = '0;
        overflow = '0;
      end
    endcase
    if (fill > peak_fill) peak_fill = fill;
    r.fill = fill;
    r.ovf = overflow;
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fault_count++;
    end
  endtask

  // input and output sampling, prediction and checking
  always @(posedge clk_i) begin : monitor
    trace_word_t   seen;
    trace_result_t want;
    trace_result_t got;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          fotb_pkg::CFG_RECORDING: rec_on = cfg_wdata_i[0];
          fotb_pkg::CFG_FILTER_LO: filt_lo = cfg_wdata_i;
          fotb_pkg::CFG_FILTER_HI: filt_hi = cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) begin
        seen = mk_word(fotb_pkg::mode_e'(mode_i), event_code_i, task_number_i, short_param_i,
                       long_param_i, stamp_i, peek_offset_i);
        want = apply_trace_word(seen);
        if (pin_typed) want = pin_result;
        pending_results.push_back(want);
      end
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        got = '{ok_o, out_stamp_o, out_event_o, out_task_o, out_short_param_o,
                out_long_param_o, fill_level_o, overflow_total_o};
        if (pending_results.size() == 0) begin
          $error("result word with nothing outstanding");
          fault_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("ok", want.ok, got.ok);
          check_field("out_stamp", want.stamp, got.stamp);
          check_field("out_event", want.evt, got.evt);
          check_field("out_task", want.tsk, got.tsk);
          check_field("out_short_param", want.sparam, got.sparam);
          check_field("out_long_param", want.lparam, got.lparam);
          check_field("fill_level", want.fill, got.fill);
          check_field("overflow_total", want.ovf, got.ovf);
        end
      end
    end
    out_ready_i <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("no handshake for %0d cycles", QUIET_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic send_word(trace_word_t w, logic typed, trace_result_t res);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= w.mode;
    event_code_i <= w.code;
    task_number_i <= w.tsk;
    short_param_i <= w.sparam;
    long_param_i <= w.lparam;
    stamp_i <= w.stamp;
    peek_offset_i <= w.offset;
    pin_typed <= typed;
    pin_result <= res;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    words_sent++;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (results_seen != words_sent) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [fotb_pkg::CfgIdxW-1:0] idx,
                           logic [fotb_pkg::CfgDataW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    trace_word_t w;
    burst_e      burst_kind;
    int unsigned burst_left;
    int unsigned pick;
    logic [63:0] lo;
    logic [63:0] hi;

    plan.push_back(word_row(mk_word(fotb_pkg::MODE_RECORD, 8'd5, 8'd1, 16'd2, 32'd3, 32'd4,
                                    8'd0),
                            1'b1, mk_result(1'b0, 0, 0, 0, 0, 0, 9'd0)));
    plan.push_back(word_row(mk_word(fotb_pkg::MODE_POP, 8'd0, 8'd0, 16'd0, 32'd0, 32'd0, 8'd0),
                            1'b1, mk_result(1'b0, 0, 0, 0, 0, 0, 9'd0)));
    plan.push_back(word_row(mk_word(fotb_pkg::MODE_PEEK, 8'd0, 8'd0, 16'd0, 32'd0, 32'd0,
                                    8'd0),
                            1'b1, mk_result(1'b0, 0, 0, 0, 0, 0, 9'd0)));
    plan.push_back(cfg_row(fotb_pkg::CFG_RECORDING, 64'd1));
    plan.push_back(word_row(mk_word(fotb_pkg::MODE_RECORD, 8'd0, 8'd0, 16'd0, 32'd0, 32'd0,
                                    8'd0),
                            1'b1, mk_result(1'b1, 0, 0, 0, 0, 0, 9'd1)));
    plan.push_back(word_row(mk_word(fotb_pkg::MODE_RECORD, 8'd127, 8'hFF, 16'hFFFF, '1, '1,
                                    8'hFF),
                            1'b1, mk_result(1'b1, 0, 0, 0, 0, 0, 9'd2)));
    plan.push_back(word_row(mk_word(fotb_pkg::MODE_RECORD, 8'd128, 8'h11, 16'h2222, 32'h3,
                                    32'h4, 8'd0),
                            1'b1, mk_result(1'b0, 0, 0, 0, 0, 0, 9'd2)));
    plan.push_back(word_row(mk_word(fotb_pkg::MODE_RECORD, 8'd255, 8'hFF, 16'hFFFF, '1, '1,
                                    8'hFF),
                            1'b1, mk_result(1'b0, 0, 0, 0, 0, 0, 9'd2)));
    plan.push_back(word_row(mk_word(fotb_pkg::MODE_PEEK, 8'd0, 8'd0, 16'd0, 32'd0, 32'd0,
                                    8'd1),
                            1'b1, mk_result(1'b1, '1, 8'd127, 8'hFF, 16'hFFFF, '1, 9'd2)));
    plan.push_back(word_row(mk_word(fotb_pkg::MODE_PEEK, 8'd0, 8'd0, 16'd0, 32'd0, 32'd0,
                                    8'd2),
                            1'b1, mk_result(1'b0, 0, 0, 0, 0, 0, 9'd2)));
    plan.push_back(word_row(mk_word(fotb_pkg::MODE_PEEK, 8'hFF, 8'hFF, 16'hFFFF, '1, '1,
                                    8'hFF),
                            1'b1, mk_result(1'b0, 0, 0, 0, 0, 0, 9'd2)));
    plan.push_back(word_row(mk_word(fotb_pkg::MODE_POP, 8'd0, 8'd0, 16'd0, 32'd0, 32'd0, 8'd0),
                            1'b1, mk_result(1'b1, 0, 0, 0, 0, 0, 9'd1)));
    plan.push_back(word_row(mk_word(fotb_pkg::MODE_POP, 8'd0, 8'd0, 16'd0, 32'd0, 32'd0, 8'd0),
                            1'b1, mk_result(1'b1, '1, 8'd127, 8'hFF, 16'hFFFF, '1, 9'd0)));
    plan.push_back(word_row(mk_word(fotb_pkg::MODE_POP, 8'd0, 8'd0, 16'd0, 32'd0, 32'd0, 8'd0),
                            1'b1, mk_result(1'b0, 0, 0, 0, 0, 0, 9'd0)));
    plan.push_back(cfg_row(fotb_pkg::CFG_FILTER_LO, 64'hAAAA_AAAA_AAAA_AAAA));
    plan.push_back(cfg_row(fotb_pkg::CFG_FILTER_HI, 64'h5555_5555_5555_5555));
    plan.push_back(word_row(mk_word(fotb_pkg::MODE_RECORD, 8'd1, 8'h5A, 16'hA5A5,
                                    32'h1234_5678, 32'h0000_0100, 8'd0), 1'b0, '0));
    plan.push_back(word_row(mk_word(fotb_pkg::MODE_RECORD, 8'd2, 8'h01, 16'h0001, 32'h1,
                                    32'h101, 8'd0), 1'b0, '0));
    plan.push_back(word_row(mk_word(fotb_pkg::MODE_RECORD, 8'd64, 8'hC3, 16'h3C3C,
                                    32'hDEAD_BEEF, 32'h0000_0102, 8'd0), 1'b0, '0));
    plan.push_back(word_row(mk_word(fotb_pkg::MODE_RECORD, 8'd65, 8'h02, 16'h0002, 32'h2,
                                    32'h103, 8'd0), 1'b0, '0));
    plan.push_back(word_row(mk_word(fotb_pkg::MODE_RECORD, 8'd63, 8'h80, 16'h8000,
                                    32'h8000_0000, 32'h8000_0000, 8'd0), 1'b0, '0));
    plan.push_back(word_row(mk_word(fotb_pkg::MODE_PEEK, 8'd0, 8'd0, 16'd0, 32'd0, 32'd0,
                                    8'd2), 1'b0, '0));
    plan.push_back(word_row(mk_word(fotb_pkg::MODE_CLEAR, 8'd0, 8'd0, 16'd0, 32'd0, 32'd0,
                                    8'd0),
                            1'b1, mk_result(1'b0, 0, 0, 0, 0, 0, 9'd0)));
    plan.push_back(cfg_row(fotb_pkg::CFG_RECORDING, 64'd0));
    plan.push_back(cfg_row(CFG_IDX_SPARE, '1));
    plan.push_back(word_row(mk_word(fotb_pkg::MODE_RECORD, 8'd1, 8'd7, 16'd7, 32'd7, 32'd7,
                                    8'd0),
                            1'b1, mk_result(1'b0, 0, 0, 0, 0, 0, 9'd0)));
    plan.push_back(word_row(mk_word(fotb_pkg::MODE_RECORD, 8'd127, 8'd9, 16'd9, 32'd9, 32'd9,
                                    8'd0), 1'b0, '0));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        settle();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_word(plan[i].word, plan[i].typed, plan[i].res);
      end
    end

    burst_left = 0;
    burst_kind = BURST_FILL;
    for (int ph = 0; ph < 8; ph++) begin
      settle();
      if (ph < 3) begin
        send_gap_pct = 19;
        sink_stall_pct = 74;
      end else if (ph < 6) begin
        send_gap_pct = 74;
        sink_stall_pct = 19;
      end else begin
        send_gap_pct = 0;
        sink_stall_pct = 0;
      end
      lo = {$urandom, $urandom};
      hi = {$urandom, $urandom};
      case (ph)
        0, 6: begin
          lo = '1;
          hi = '1;
        end
        2: lo = '0;
        3: hi = '0;
        default: ;
      endcase
      write_reg(fotb_pkg::CFG_RECORDING, (ph == 4) ? 64'd0 : 64'd1);
      write_reg(fotb_pkg::CFG_FILTER_LO, lo);
      write_reg(fotb_pkg::CFG_FILTER_HI, hi);
      if (ph == 4) write_reg(CFG_IDX_SPARE, {$urandom, $urandom});

      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (burst_left == 0) begin
          burst_kind = burst_e'($urandom_range(2));
          burst_left = (burst_kind == BURST_FILL) ? $urandom_range(320, 20)
                                                  : $urandom_range(60, 5);
        end
        burst_left--;
        pick = $urandom_range(99);
        case (burst_kind)
          BURST_FILL:
            w.mode = (pick < 90) ? fotb_pkg::MODE_RECORD :
                     (pick < 95) ? fotb_pkg::MODE_PEEK : fotb_pkg::MODE_POP;
          BURST_DRAIN:
            w.mode = (pick < 15) ? fotb_pkg::MODE_RECORD : (pick < 55) ? fotb_pkg::MODE_POP :
                     (pick < 98) ? fotb_pkg::MODE_PEEK : fotb_pkg::MODE_CLEAR;
          default:
            w.mode = (pick < 45) ? fotb_pkg::MODE_RECORD : (pick < 70) ? fotb_pkg::MODE_POP :
                     (pick < 98) ? fotb_pkg::MODE_PEEK : fotb_pkg::MODE_CLEAR;
        endcase
        w.code = ($urandom_range(99) < 85) ? 8'($urandom_range(127))
                                           : 8'($urandom_range(255, 128));
        w.tsk = 8'($urandom_range(255));
        w.sparam = 16'($urandom_range(16'hFFFF));
        w.lparam = $urandom;
        w.stamp = $urandom;
        w.offset = (fill != 0 && $urandom_range(99) < 70) ? 8'($urandom_range(fill - 1))
                                                          : 8'($urandom_range(255));
        send_word(w, 1'b0, '0);
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $error("%0d result words never arrived", pending_results.size());
      fault_count++;
    end
    $display("%0d words over 8 register settings: %0d entries kept, %0d returned",
             words_sent, kept_count, returned_count);
    $display("%0d entries overwritten on a full ring, peak fill %0d, %0d faults",
             overwrite_count, peak_fill, fault_count);
    if (fault_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/fotb_pkg.sv
hw/rtl/fotb_ctrl.sv
hw/rtl/fotb_dp.sv
hw/rtl/filtered_overwriting_trace_buffer_unit.sv
bench/tb_top.sv
